// File: hw/rtl/bbrs_pkg.sv
// Shared types and constants for the block bit rotate scrambler.
`default_nettype none
package bbrs_pkg;

  // Stream and register widths
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Default largest block length in bits
  localparam int MAX_BLOCK_BITS_DEF = 64;

  // Register reset values
  localparam logic [LEN_W-1:0] BLOCK_SIZE_RST = 7'd8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UNSCRAMBLE = 1'b1;

  // Rotation modes
  localparam logic MODE_ROTR = 1'b0;
  localparam logic MODE_ROTL = 1'b1;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // One classified input word: the byte, where blocks close inside it
  // (bit position 0 is the byte's MSB) and the length of each closing block.
  typedef struct packed {
    logic [BYTE_W-1:0]             data;
    logic [BYTE_W-1:0]             close;
    logic [BYTE_W-1:0][LEN_W-1:0]  len;
    logic [LEN_W-1:0]              fill_after;
    logic                          mode;
    logic                          last;
  } entry_t;

endpackage
`default_nettype wire

// File: hw/rtl/bbrs_front.sv
// Front end: configuration registers, input acceptance and block-close classification.
`default_nettype none
module bbrs_front #(
  parameter int MAX_BLOCK_BITS = bbrs_pkg::MAX_BLOCK_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bbrs_pkg::BYTE_W-1:0]       in_tdata,
  input  logic                              in_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bbrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bbrs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              push_valid,
  input  logic                              push_ready,
  output bbrs_pkg::entry_t                  push_entry
);
  import bbrs_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BLOCK_BITS);

  logic [LEN_W-1:0]             block_size_r, block_size_nxt;
  logic                         mode_r, mode_nxt;
  logic [LEN_W-1:0]             fill_r, fill_nxt;
  logic [LEN_W-1:0]             eff_size;
  logic [LEN_W-1:0]             f_run;
  logic [BYTE_W-1:0]            cls;
  logic [BYTE_W-1:0][LEN_W-1:0] lens;
  logic                         accept;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_comb begin
    block_size_nxt = block_size_r;
    mode_nxt       = mode_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_BLOCK_SIZE: block_size_nxt = cfg_data;
        REG_UNSCRAMBLE: mode_nxt       = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Block size clamped to 1..MAX
  assign eff_size = (block_size_r == '0) ? LEN_W'(1) :
                    ((block_size_r > MAX_LEN) ? MAX_LEN : block_size_r);

  // Walk the eight bits MSB first, marking where blocks close
  always_comb begin
    f_run = fill_r;
    cls   = '0;
    lens  = '0;
    for (int p = 0; p < BYTE_W; p++) begin
      f_run = f_run + LEN_W'(1);
      if (f_run >= eff_size) begin
        cls[p]  = 1'b1;
        lens[p] = f_run;
        f_run   = '0;
      end
    end
    // End of message flushes a short block
    if (in_tlast && (f_run != '0)) begin
      cls[BYTE_W-1]  = 1'b1;
      lens[BYTE_W-1] = f_run;
      f_run          = '0;
    end
  end

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;
  assign accept     = in_tvalid && push_ready;

  always_comb begin
    push_entry.data       = in_tdata;
    push_entry.close      = cls;
    push_entry.len        = lens;
    push_entry.fill_after = f_run;
    push_entry.mode       = mode_r;
    push_entry.last       = in_tlast;
  end

  assign fill_nxt = accept ? f_run : fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BLOCK_SIZE_RST;
      mode_r       <= MODE_ROTR;
      fill_r       <= '0;
    end else begin
      block_size_r <= block_size_nxt;
      mode_r       <= mode_nxt;
      fill_r       <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bbrs_queue.sv
// Short FIFO of classified words between front and back end.
`default_nettype none
module bbrs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  bbrs_pkg::entry_t push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output bbrs_pkg::entry_t pop_entry
);
  import bbrs_pkg::*;

  entry_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];

  assign do_push = push_valid && push_ready;
  assign do_pop  = pop_valid && pop_ready;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bbrs_back.sv
// Back end: bit buffer, in-place block rotation and byte output register.
`default_nettype none
module bbrs_back #(
  parameter int MAX_BLOCK_BITS = bbrs_pkg::MAX_BLOCK_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  bbrs_pkg::entry_t            q_entry,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [bbrs_pkg::BYTE_W-1:0] out_tdata,
  output logic                        out_tlast
);
  import bbrs_pkg::*;

  // Pending bits never exceed MAX+6 before a word is appended
  localparam int NSLOT = (MAX_BLOCK_BITS + 6) / 8 + 1;
  localparam int RW    = NSLOT * BYTE_W;
  localparam int IW    = $clog2(RW);
  localparam int SIW   = $clog2(NSLOT);
  localparam int CW    = $clog2(NSLOT + 1);

  // Byte slots, newest in slot 0; only the low cnt_r slots are live
  logic [NSLOT-1:0][BYTE_W-1:0] slots_r, slots_nxt;
  logic [NSLOT-1:0]             lastf_r, lastf_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt, cnt_ae;
  logic [LEN_W-1:0]             fill_r, fill_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]            out_data_r, out_data_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [SIW-1:0]               top_idx;
  logic                         top_final, emit, take;
  logic [RW-1:0]                flat, app, shr, shl, rot;
  logic [BYTE_W-1:0][IW-1:0]    hi;
  logic [BYTE_W-1:0]            hib, lob;
  logic                         inw, hhit, lhit, ph, pl;

  // Oldest byte can leave once it lies wholly above the open block
  assign top_idx   = SIW'(cnt_r - CW'(1));
  assign top_final = (cnt_r != '0) && ({top_idx, 3'b000} >= fill_r);
  assign emit      = top_final && (!out_valid_r || out_tready);
  assign cnt_ae    = cnt_r - CW'(emit);
  assign take      = q_valid && (cnt_ae < CW'(NSLOT));
  assign q_ready   = take;
  assign cnt_nxt   = cnt_ae + CW'(take);

  // Append the word and rotate every block closing in it, in place
  assign flat = slots_r;
  assign app  = {flat[RW-BYTE_W-1:0], q_entry.data};
  assign shr  = app >> 1;
  assign shl  = app << 1;

  always_comb begin
    for (int p = 0; p < BYTE_W; p++) begin
      hi[p]  = IW'(q_entry.len[p] + LEN_W'(BYTE_W - 1 - p) - LEN_W'(1));
      hib[p] = app[hi[p]];
      lob[p] = app[BYTE_W - 1 - p];
    end
  end

  always_comb begin
    rot  = app;
    inw  = 1'b0;
    hhit = 1'b0;
    lhit = 1'b0;
    ph   = 1'b0;
    pl   = 1'b0;
    for (int i = 0; i < RW; i++) begin
      inw  = 1'b0;
      hhit = 1'b0;
      lhit = 1'b0;
      ph   = 1'b0;
      pl   = 1'b0;
      for (int p = 0; p < BYTE_W; p++) begin
        if (q_entry.close[p]) begin
          if ((IW'(i) >= IW'(BYTE_W - 1 - p)) && (IW'(i) <= hi[p])) begin
            inw = 1'b1;
          end
          if (IW'(i) == hi[p]) begin
            hhit = 1'b1;
            ph   = lob[p];
          end
          if (i == BYTE_W - 1 - p) begin
            lhit = 1'b1;
            pl   = hib[p];
          end
        end
      end
      if (q_entry.mode == MODE_ROTR) begin
        rot[i] = hhit ? ph : (inw ? shr[i] : app[i]);
      end else begin
        rot[i] = lhit ? pl : (inw ? shl[i] : app[i]);
      end
    end
  end

  always_comb begin
    slots_nxt = take ? rot : slots_r;
    lastf_nxt = take ? {lastf_r[NSLOT-2:0], q_entry.last} : lastf_r;
    fill_nxt  = take ? q_entry.fill_after : fill_r;
  end

  // Output register
  always_comb begin
    out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    out_data_nxt  = emit ? slots_r[top_idx] : out_data_r;
    out_last_nxt  = emit ? lastf_r[top_idx] : out_last_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slots_r    <= slots_nxt;
    lastf_r    <= lastf_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
`default_nettype wire

// File: hw/rtl/block_bit_rotate_scrambler.sv
// Top level of the block bit rotate scrambler. The message arrives as bytes
// read MSB first and is cut into blocks of block_size bits (1..MAX_BLOCK_BITS,
// 0 acts as 1); each block is rotated right by one bit (unscramble_mode 0) or
// left by one (unscramble_mode 1), a short final block rotating within its own
// length, and the result leaves as bytes with tlast on the final one. Both
// sides sustain one word per clock while out_tready is high. The front end
// classifies each input word in the cycle it is accepted and feeds a two-entry
// queue; the back end appends one word per clock, while a slot is free, to a
// byte buffer of (MAX_BLOCK_BITS+6)/8+1 bytes and drains it through the output
// register at one byte per clock while out_tready is high, so a word that
// closes a long block releases up to nine bytes over the following clocks while
// input continues into the free buffer space. Configuration is to be written
// through the cfg port only while no message is in flight, which the block does
// not enforce; the block size and mode in force are sampled per word.
`default_nettype none
module block_bit_rotate_scrambler #(
  parameter int MAX_BLOCK_BITS = bbrs_pkg::MAX_BLOCK_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bbrs_pkg::BYTE_W-1:0]       in_tdata,   // [7:0] data_in
  input  logic                              in_tlast,   // last_in
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bbrs_pkg::BYTE_W-1:0]       out_tdata,  // [7:0] data_out
  output logic                              out_tlast,  // last_out
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bbrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bbrs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bbrs_pkg::*;

  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   pop_valid, pop_ready;
  entry_t pop_entry;

  bbrs_front #(.MAX_BLOCK_BITS(MAX_BLOCK_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  bbrs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  bbrs_back #(.MAX_BLOCK_BITS(MAX_BLOCK_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_entry    (pop_entry),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// File: hw/rtl/bbrs_checker.sv
// Port-level checks for the scrambler top level, bound to every instance.
`default_nettype none
module bbrs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [bbrs_pkg::BYTE_W-1:0]     in_tdata,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bbrs_pkg::BYTE_W-1:0]     out_tdata,
  input logic                            out_tlast,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);

  // A stalled output word holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // A stalled input word stays on the bus
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tlast))
    else $error("input word changed while stalled");

  // Register writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("register write stalled");

  // Reset empties the byte buffer and output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // Reset empties the queue, so input is taken at once
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready right after reset");

endmodule

bind block_bit_rotate_scrambler bbrs_checker u_bbrs_checker (.*);
`default_nettype wire

// File: tb/block_bit_rotate_scrambler_tb.sv
// Testbench for the block bit rotate scrambler: stream driver, monitor and scrambling predictor.
`timescale 1ns / 100ps

module block_bit_rotate_scrambler_tb;
  import bbrs_pkg::*;

  localparam int WD_LIMIT    = 3000;  // cycles without any handshake
  localparam int SETTLE_CYC  = 12;    // drain time after the last expected word
  localparam int STALL_CYC   = 200;   // long receiver hold-off
  localparam int STALL_AT    = 32;    // pending input words that start the hold-off

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } byte_word_t;

  // DUT inputs, known from time zero
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [BYTE_W-1:0]     in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  logic              in_tready;
  logic              out_tvalid;
  logic [BYTE_W-1:0] out_tdata;
  logic              out_tlast;
  logic              cfg_ready;

  // Stimulus and expectation stores
  byte_word_t tx_bytes[$];
  byte_word_t expected_bytes[$];

  // Predictor copy of registers and state
  logic [LEN_W-1:0]  blk_size_reg = BLOCK_SIZE_RST;
  logic              mode_reg     = MODE_ROTR;
  logic [63:0]       blk_bits     = '0;
  int                blk_len      = 0;
  logic [7:0]        ob_bits      = '0;
  int                ob_len       = 0;

  int  snd_idle   = 23;
  int  rcv_idle   = 64;
  int  err_count  = 0;
  int  wd_count   = 0;
  int  stall_left = 0;
  bit  stall_done = 1'b0;
  bit  in_taken   = 1'b0;

  block_bit_rotate_scrambler u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Block length in force: zero acts as one, large values saturate
  function automatic int eff_block_len();
    int s;
    s = int'(blk_size_reg);
    if (s < 1) s = 1;
    if (s > MAX_BLOCK_BITS_DEF) s = MAX_BLOCK_BITS_DEF;
    return s;
  endfunction

  // Append a bit to the output byte; full bytes, nine per input byte at most, become expected words
  task automatic shift_out_bit(input logic b, inout int n_words);
    byte_word_t w;
    ob_bits = {ob_bits[6:0], b};
    ob_len++;
    if (ob_len >= 8) begin
      if (n_words < 9) begin
        w.data = ob_bits;
        w.last = 1'b0;
        expected_bytes.push_back(w);
        n_words++;
      end
      ob_bits = '0;
      ob_len  = 0;
    end
  endtask

  // Rotate the open block by one and send its bits out, oldest first
  task automatic rotate_block(inout int n_words);
    logic [63:0] mask;
    logic [63:0] v;
    int          len;
    len = blk_len;
    if (len == 0) return;
    if (len > 64) len = 64;
    mask = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
    v = blk_bits & mask;
    if (mode_reg == MODE_ROTR)
      v = (v >> 1) | ((v & 64'd1) << (len - 1));
    else
      v = ((v << 1) & mask) | ((v >> (len - 1)) & 64'd1);
    for (int i = len; i > 0; i--)
      shift_out_bit(v[i-1], n_words);
    blk_bits = '0;
    blk_len  = 0;
  endtask

  // Scramble one accepted input byte into its expected output words
  task automatic scramble_byte(input logic [7:0] b, input logic lst);
    int         n_words;
    byte_word_t w;
    n_words = 0;
    for (int i = 7; i >= 0; i--) begin
      blk_bits = {blk_bits[62:0], b[i]};
      blk_len++;
      if (blk_len >= eff_block_len() || blk_len >= 64)
        rotate_block(n_words);
    end
    if (lst) begin
      rotate_block(n_words);
      while (ob_len != 0)
        shift_out_bit(1'b0, n_words);
      if (n_words > 0) begin
        w = expected_bytes.pop_back();
        w.last = 1'b1;
        expected_bytes.push_back(w);
      end
      blk_bits = '0;
      blk_len  = 0;
      ob_bits  = '0;
      ob_len   = 0;
    end
  endtask

  // Input acceptance and prediction
  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      scramble_byte(in_tdata, in_tlast);
      void'(tx_bytes.pop_front());
    end
  end

  // Input driver: hold an offered word until taken, idle at random otherwise
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // keep the word on the bus
    end else if (tx_bytes.size() != 0 && $urandom_range(99) >= snd_idle) begin
      in_tvalid <= 1'b1;
      in_tdata  <= tx_bytes[0].data;
      in_tlast  <= tx_bytes[0].last;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && tx_bytes.size() >= STALL_AT) begin
      out_tready <= 1'b0;
      stall_left <= STALL_CYC;
      stall_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Output monitor
  always @(posedge clk) begin
    byte_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected output word data_out=%02h last_out=%0d", out_tdata, out_tlast);
        err_count++;
      end else begin
        w = expected_bytes.pop_front();
        if (out_tdata !== w.data) begin
          $error("data_out mismatch: expected %02h, actual %02h", w.data, out_tdata);
          err_count++;
        end
        if (out_tlast !== w.last) begin
          $error("last_out mismatch: expected %0d, actual %0d", w.last, out_tlast);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      wd_count <= 0;
    else
      wd_count <= wd_count + 1;
    if (wd_count >= WD_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Register write through the cfg channel
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BLOCK_SIZE)
      blk_size_reg = val;
    else
      mode_reg = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_word(input logic [7:0] d, input logic lst);
    byte_word_t w;
    w.data = d;
    w.last = lst;
    tx_bytes.push_back(w);
  endtask

  // Wait until every queued word went in and every expected word came out
  task automatic settle();
    do @(negedge clk); while (tx_bytes.size() != 0 || expected_bytes.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Random block size and mode, extremes included
  task automatic random_config();
    int r;
    logic [CFG_DATA_W-1:0] sz;
    r = $urandom_range(99);
    if (r < 50)      sz = CFG_DATA_W'($urandom_range(16, 1));
    else if (r < 75) sz = CFG_DATA_W'($urandom_range(64, 17));
    else if (r < 85) sz = 7'd0;
    else if (r < 92) sz = 7'd64;
    else             sz = CFG_DATA_W'($urandom_range(127, 65));
    write_reg(REG_BLOCK_SIZE, sz);
    write_reg(REG_UNSCRAMBLE, CFG_DATA_W'($urandom_range(127)));
  endtask

  // Messages of random length and content; sometimes the phase stops mid-message
  task automatic random_messages(input int n_words);
    int  cnt;
    int  len;
    int  r;
    bit  leave_open;
    logic [7:0] d;
    cnt = 0;
    leave_open = ($urandom_range(3) == 0);
    while (cnt < n_words) begin
      r = $urandom_range(99);
      if (r < 70)      len = $urandom_range(6, 1);
      else if (r < 90) len = $urandom_range(12, 7);
      else             len = $urandom_range(20, 13);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(15) == 0) d = $urandom_range(1) ? 8'hFF : 8'h00;
        else                         d = 8'($urandom_range(255));
        push_word(d, (i == len - 1) && !(leave_open && cnt + len >= n_words));
      end
      cnt += len;
    end
  endtask

  // Main sequence
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: extremes of the byte, single-byte message
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h80, 1'b0);
    push_word(8'h01, 1'b1);
    push_word(8'hA5, 1'b1);
    settle();

    // One-bit blocks, left rotation
    write_reg(REG_BLOCK_SIZE, 7'd1);
    write_reg(REG_UNSCRAMBLE, {6'h3F, MODE_ROTL});
    @(posedge clk);
    push_word(8'h5A, 1'b0);
    push_word(8'hC3, 1'b1);
    settle();

    // Size zero acts as one
    write_reg(REG_BLOCK_SIZE, 7'd0);
    write_reg(REG_UNSCRAMBLE, {6'h3E, MODE_ROTR});
    @(posedge clk);
    push_word(8'h96, 1'b1);
    settle();

    // Largest block, then a short final block
    write_reg(REG_BLOCK_SIZE, 7'd64);
    @(posedge clk);
    push_word(8'h80, 1'b0);
    for (int i = 0; i < 6; i++) push_word(8'h00, 1'b0);
    push_word(8'h01, 1'b0);
    push_word(8'h81, 1'b1);
    settle();

    // Oversized block saturates; short final block rotated left
    write_reg(REG_BLOCK_SIZE, 7'd127);
    write_reg(REG_UNSCRAMBLE, {6'h00, MODE_ROTL});
    @(posedge clk);
    push_word(8'h01, 1'b0);
    push_word(8'h80, 1'b1);
    settle();

    // Message left open, then size and mode changed mid-block
    write_reg(REG_BLOCK_SIZE, 7'd13);
    @(posedge clk);
    push_word(8'hFF, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h01, 1'b0);
    settle();
    write_reg(REG_BLOCK_SIZE, 7'd5);
    write_reg(REG_UNSCRAMBLE, {6'h15, MODE_ROTR});
    @(posedge clk);
    push_word(8'hAA, 1'b1);
    settle();

    // Long message against the receiver hold-off, so the input stalls
    write_reg(REG_BLOCK_SIZE, 7'd24);
    @(posedge clk);
    for (int i = 0; i < 40; i++) push_word(8'(i * 37 + 11), i == 39);
    settle();

    // Random phases under three idling regimes
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          snd_idle = 23;
          rcv_idle = 64;
        end
        1: begin
          snd_idle = 64;
          rcv_idle = 23;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      for (int ph = 0; ph < 6; ph++) begin
        random_config();
        @(posedge clk);
        random_messages(12);
        settle();
      end
    end

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: block_bit_rotate_scrambler.f
hw/rtl/bbrs_pkg.sv
hw/rtl/bbrs_front.sv
hw/rtl/bbrs_queue.sv
hw/rtl/bbrs_back.sv
hw/rtl/block_bit_rotate_scrambler.sv
hw/rtl/bbrs_checker.sv
tb/block_bit_rotate_scrambler_tb.sv
